FILE: sv/wavhp_pkg.sv
// Shared types and constants for the WAV header parser.
package wavhp_pkg;

  localparam int BYTE_W    = 8;
  localparam int RATE_W    = 18;
  localparam int STAT_W    = 3;
  localparam int CH_W      = 2;
  localparam int FRAME_W   = 3;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 1'd1;

  localparam logic [RATE_W-1:0] MIN_RATE_RST = 18'd8000;
  localparam logic [RATE_W-1:0] MAX_RATE_RST = 18'd48000;

  // Four-character codes as they appear little-endian in a 32-bit word.
  localparam logic [WORD_W-1:0] MAGIC_RIFF = 32'h4646_4952;
  localparam logic [WORD_W-1:0] MAGIC_WAVE = 32'h4556_4157;
  localparam logic [WORD_W-1:0] ID_FMT     = 32'h2074_6D66;
  localparam logic [WORD_W-1:0] ID_DATA    = 32'h6174_6164;

  localparam logic [CNT_W-1:0]  FMT_EXAMINE = 6'd40;
  localparam logic [WORD_W-1:0] FMT_MIN     = 32'd16;
  localparam logic [CNT_W-1:0]  RIFF_LAST   = 6'd11;
  localparam logic [CNT_W-1:0]  HDR_LAST    = 6'd7;
  localparam logic [15:0]       FMT_PCM     = 16'd1;
  localparam logic [15:0]       PCM_BITS    = 16'd16;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_TRUNC   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_UNSUP   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    PH_RIFF = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_FMT  = 5'b00100,
    PH_SKIP = 5'b01000,
    PH_PAD  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    status_t            status;
    logic [RATE_W-1:0]  sample_rate;
    logic [CH_W-1:0]    channel_count;
    logic [FRAME_W-1:0] block_align;
    logic [WORD_W-1:0]  payload_offset;
    logic [WORD_W-1:0]  payload_size;
  } result_t;

  typedef struct packed {
    logic [RATE_W-1:0] min_rate;
    logic [RATE_W-1:0] max_rate;
  } cfg_t;

endpackage

FILE: sv/wavhp_if.sv
// Handshake interfaces for the byte input channel and the result channel.
interface wavhp_in_if import wavhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface wavhp_out_if import wavhp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [RATE_W-1:0]  sample_rate;
  logic [CH_W-1:0]    channel_count;
  logic [FRAME_W-1:0] block_align;
  logic [WORD_W-1:0]  payload_offset;
  logic [WORD_W-1:0]  payload_size;

  modport source (output valid, output status, output sample_rate, output channel_count,
                  output block_align, output payload_offset, output payload_size,
                  input ready);
  modport sink (input valid, input status, input sample_rate, input channel_count,
                input block_align, input payload_offset, input payload_size,
                output ready);
endinterface

FILE: sv/wavhp_in_stage.sv
// Input register stage for incoming file bytes.
module wavhp_in_stage import wavhp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  wavhp_in_if.sink  in_bus,
  input  logic      advance,
  output stage_t    stage
);

  logic  valid_r;
  item_t item_r;

  // The register refills whenever its item moves on or it is empty.
  assign in_bus.ready = !valid_r || advance;
  assign stage        = '{valid: valid_r, item: item_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r <= '{data_byte: in_bus.data_byte, last: in_bus.last};
    end
  end

endmodule

FILE: sv/wavhp_parse.sv
// Parser state and the per-byte update of the RIFF/WAVE chunk walker.
module wavhp_parse import wavhp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    go,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t res
);

  phase_t             phase_r, phase_nxt;
  logic [WORD_W-1:0]  pos_r, pos_nxt;
  logic [63:0]        shift_r, shift_nxt;
  logic [WORD_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0]  csize_r, csize_nxt;
  logic [63:0]        fmt_r, fmt_nxt;
  logic [1:0]         seen_r, seen_nxt;
  logic [WORD_W-1:0]  foff_r, foff_nxt;
  logic [WORD_W-1:0]  fsize_r, fsize_nxt;
  logic               fin_r, fin_nxt;

  logic [BYTE_W-1:0]  b;
  logic [CNT_W-1:0]   cnt6;
  logic [CNT_W-1:0]   to_read;
  logic [63:0]        shift_in;
  logic [63:0]        fmt_tail;
  logic [WORD_W-1:0]  hdr_id;
  logic [WORD_W-1:0]  hdr_size;
  logic               fmt_bad;
  logic               do_skip;
  logic [WORD_W-1:0]  skip_len;
  logic               end_pay;
  logic               emit;
  status_t            emit_st;

  assign b       = item.data_byte;
  assign cnt6    = cnt_r[CNT_W-1:0];
  assign to_read = (csize_r < {{(WORD_W-CNT_W){1'b0}}, FMT_EXAMINE}) ?
                   csize_r[CNT_W-1:0] : FMT_EXAMINE;
  assign shift_in = {b, shift_r[63:8]};
  assign hdr_id   = shift_in[31:0];
  assign hdr_size = shift_in[63:32];
  // The sixteenth fmt byte completes the bits field in the same cycle.
  assign fmt_tail = (cnt6 == 6'd15) ? {b, shift_r[55:0]} : shift_r;

  // Format check. The first eight fmt bytes are already registered when the
  // check runs; the second eight may still include the byte of this cycle.
  always_comb begin
    fmt_bad = (fmt_r[15:0] != FMT_PCM) ||
              !(fmt_r[31:16] inside {16'd1, 16'd2}) ||
              (fmt_tail[63:48] != PCM_BITS) ||
              (fmt_tail[47:32] != {fmt_r[30:16], 1'b0}) ||
              (fmt_r[63:32] < {{(WORD_W-RATE_W){1'b0}}, cfg.min_rate}) ||
              (fmt_r[63:32] > {{(WORD_W-RATE_W){1'b0}}, cfg.max_rate});
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    csize_nxt = csize_r;
    fmt_nxt   = fmt_r;
    seen_nxt  = seen_r;
    foff_nxt  = foff_r;
    fsize_nxt = fsize_r;
    fin_nxt   = fin_r;
    do_skip   = 1'b0;
    skip_len  = '0;
    end_pay   = 1'b0;
    emit      = 1'b0;
    emit_st   = ST_OK;

    if (go && !fin_r) begin
      pos_nxt = pos_r + 32'd1;
      case (phase_r)
        PH_RIFF: begin
          // Only the RIFF and WAVE tags are kept; the file size is dropped.
          if (!(cnt6 inside {[6'd4:6'd7]})) begin
            shift_nxt = {b, shift_r[63:8]};
          end
          cnt_nxt = cnt_r + 32'd1;
          if (cnt6 == RIFF_LAST) begin
            if (shift_nxt[31:0] != MAGIC_RIFF || shift_nxt[63:32] != MAGIC_WAVE) begin
              emit    = 1'b1;
              emit_st = ST_MAGIC;
            end else begin
              phase_nxt = PH_HDR;
              cnt_nxt   = '0;
            end
          end
        end
        PH_HDR: begin
          shift_nxt = shift_in;
          cnt_nxt   = cnt_r + 32'd1;
          if (cnt6 == HDR_LAST) begin
            csize_nxt = hdr_size;
            cnt_nxt   = '0;
            if (hdr_id == ID_FMT) begin
              if (hdr_size < FMT_MIN) begin
                emit    = 1'b1;
                emit_st = ST_MAGIC;
              end else begin
                phase_nxt = PH_FMT;
              end
            end else if (hdr_id == ID_DATA) begin
              foff_nxt    = pos_nxt;
              fsize_nxt   = hdr_size;
              seen_nxt[1] = 1'b1;
              if (seen_r[0]) begin
                emit    = 1'b1;
                emit_st = (hdr_size == '0) ? ST_MISSING : ST_OK;
              end else begin
                do_skip  = 1'b1;
                skip_len = hdr_size;
              end
            end else begin
              do_skip  = 1'b1;
              skip_len = hdr_size;
            end
          end
        end
        PH_FMT: begin
          // Every decoded byte is written before the check, so no clear is needed.
          if (cnt6 < 6'd8) begin
            fmt_nxt[{cnt6[2:0], 3'b000} +: BYTE_W] = b;
          end else if (cnt6 < 6'd16) begin
            shift_nxt[{cnt6[2:0], 3'b000} +: BYTE_W] = b;
          end
          cnt_nxt = cnt_r + 32'd1;
          if (cnt6 + 6'd1 == to_read) begin
            if (fmt_bad) begin
              emit    = 1'b1;
              emit_st = ST_UNSUP;
            end else begin
              seen_nxt[0] = 1'b1;
              if (seen_r[1]) begin
                emit    = 1'b1;
                emit_st = (fsize_r == '0) ? ST_MISSING : ST_OK;
              end else begin
                do_skip  = 1'b1;
                skip_len = csize_r - {{(WORD_W-CNT_W){1'b0}}, to_read};
              end
            end
          end
        end
        PH_SKIP: begin
          cnt_nxt = cnt_r - 32'd1;
          if (cnt_r == 32'd1) begin
            end_pay = 1'b1;
          end
        end
        PH_PAD: begin
          phase_nxt = PH_HDR;
          cnt_nxt   = '0;
        end
        default: begin
          phase_nxt = PH_HDR;
          cnt_nxt   = '0;
        end
      endcase

      if (do_skip) begin
        if (skip_len == '0) begin
          end_pay = 1'b1;
        end else begin
          phase_nxt = PH_SKIP;
          cnt_nxt   = skip_len;
        end
      end
      if (end_pay) begin
        phase_nxt = csize_nxt[0] ? PH_PAD : PH_HDR;
        cnt_nxt   = '0;
      end
      if (emit) begin
        fin_nxt = 1'b1;
      end
    end

    res = '0;
    res.status = emit_st;
    if (emit_st == ST_OK) begin
      res.sample_rate    = fmt_nxt[32 +: RATE_W];
      res.channel_count  = fmt_nxt[16 +: CH_W];
      res.block_align    = {fmt_nxt[16 +: CH_W], 1'b0};
      res.payload_offset = foff_nxt;
      res.payload_size   = fsize_nxt;
    end

    // End of file: report once if nothing was reported, then start over.
    if (go && item.last) begin
      if (!fin_nxt) begin
        emit = 1'b1;
        res  = '0;
        res.status = (phase_nxt == PH_RIFF || phase_nxt == PH_FMT) ? ST_TRUNC : ST_MISSING;
      end
      phase_nxt = PH_RIFF;
      pos_nxt   = '0;
      shift_nxt = '0;
      cnt_nxt   = '0;
      csize_nxt = '0;
      fmt_nxt   = '0;
      seen_nxt  = '0;
      foff_nxt  = '0;
      fsize_nxt = '0;
      fin_nxt   = 1'b0;
    end

    res_valid = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      pos_r   <= '0;
      shift_r <= '0;
      cnt_r   <= '0;
      csize_r <= '0;
      fmt_r   <= '0;
      seen_r  <= '0;
      foff_r  <= '0;
      fsize_r <= '0;
      fin_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      csize_r <= csize_nxt;
      fmt_r   <= fmt_nxt;
      seen_r  <= seen_nxt;
      foff_r  <= foff_nxt;
      fsize_r <= fsize_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

FILE: sv/wav_header_parser_core.sv
// Top level of the byte-serial RIFF/WAVE header parser.
//
// Usage: a WAV file enters one byte per item on in_bus (data_byte, with last
// set on the final byte of the file). The block checks the RIFF/WAVE magic,
// walks the chunk list, decodes the fmt chunk and locates the data chunk.
// It sends at most one result item per file on out_bus: when fmt and data are
// both known, on the first error, or at the end of the file. After a result,
// bytes are dropped until last, and the byte after last starts a new file.
// Throughput is one byte per cycle while the output register can take a result;
// the single state update per byte is the only loop. A byte that causes a result
// is first loaded into the input register; the parser update then runs on it and
// loads the result into the output register.
// When the receiver stalls with a result waiting, the parser and the input
// register hold, and in_bus.ready stays low while the input register holds a
// byte; nothing is dropped.
// Reset (rst_n low at a clock edge) returns the parser to the start of a file
// and loads the sample-rate window with 8000 to 48000 Hz. The user must write it
// via cfg_we/cfg_index/cfg_data with no file in flight; not enforced by the block.
module wav_header_parser_core import wavhp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  wavhp_in_if.sink              in_bus,
  wavhp_out_if.source           out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [RATE_W-1:0]     cfg_data
);

  logic [RATE_W-1:0] min_rate_r;
  logic [RATE_W-1:0] max_rate_r;
  cfg_t              cfg;

  stage_t  stage;
  logic    take;
  logic    go;
  logic    res_valid;
  result_t res;

  logic    out_valid_r;
  result_t out_res_r;

  // Sample-rate window registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rate_r <= MIN_RATE_RST;
      max_rate_r <= MAX_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_RATE: min_rate_r <= cfg_data;
        CFG_MAX_RATE: max_rate_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{min_rate: min_rate_r, max_rate: max_rate_r};

  // A byte is processed whenever the output register can take a result,
  // whether or not this byte produces one.
  assign take = !out_valid_r || out_bus.ready;
  assign go   = stage.valid && take;

  wavhp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .advance (take),
    .stage   (stage)
  );

  wavhp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .item      (stage.item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.status         = out_res_r.status;
  assign out_bus.sample_rate    = out_res_r.sample_rate;
  assign out_bus.channel_count  = out_res_r.channel_count;
  assign out_bus.block_align    = out_res_r.block_align;
  assign out_bus.payload_offset = out_res_r.payload_offset;
  assign out_bus.payload_size   = out_res_r.payload_size;

`ifndef SYNTH
  // A good result always carries one or two channels and a matching frame size.
  a_ok_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.status == ST_OK) |->
      ((out_bus.channel_count == 2'd1 || out_bus.channel_count == 2'd2) &&
       out_bus.block_align == {out_bus.channel_count, 1'b0}))
    else $error("result with status ok has an inconsistent channel layout");

  // A new result only appears after a byte was processed.
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(go))
    else $error("result appeared without a processed byte");

  // A stalled byte in the input register must stay there.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.valid && !take) |=> stage.valid)
    else $error("input register lost a byte during a stall");
`endif

endmodule
